FILE: src/idw_pkg.sv
package idw_pkg;

	localparam int MAX_POINTS = 64;
	localparam int PT_W       = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int COORD_W    = 24;
	localparam int TEMP_W     = 16;
	localparam int POW_W      = 4;
	localparam int W_FRAC     = 20;
	localparam int WT_W       = W_FRAC + 1;
	localparam int SQ_W       = 2 * COORD_W;
	localparam int D2_W       = SQ_W + 1;
	localparam int REM_W      = D2_W + 1;
	localparam int WSUM_W     = WT_W + PT_W;
	localparam int PROD_W     = WT_W + 1 + TEMP_W;
	localparam int VSUM_W     = PROD_W + PT_W - 1;
	localparam int NUM_W      = VSUM_W + 2;
	localparam int ROOT_IN_W  = 2 * WT_W;
	localparam int STEP_W     = 6;
	localparam int RATIO_STEPS = W_FRAC;

	localparam logic [WT_W-1:0]  W_ONE = WT_W'(1) << W_FRAC;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

	typedef enum logic [1:0] {
		REG_POWER = 2'd0,
		REG_COUNT = 2'd1
	} reg_idx_t;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef struct packed {
		logic                      action;
		logic [5:0]                slot;
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [TEMP_W-1:0]  temp_in;
		logic                      temp_valid;
		logic                      cell_valid;
	} in_item_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_out;
		logic                     out_valid;
	} out_item_t;

	typedef struct packed {
		logic                      ok;
		logic signed [TEMP_W-1:0]  temp;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} ref_entry_t;

	localparam int ENTRY_W = $bits(ref_entry_t);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_DAT,
		S_SQ,
		S_NEXT,
		S_RATIO,
		S_WGT,
		S_ROOT,
		S_POW,
		S_ACC,
		S_FIN,
		S_QUO,
		S_EMIT
	} idw_state_t;

endpackage

FILE: src/idw_ram.sv
module idw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/idw_div.sv
module idw_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [idw_pkg::D2_W-1:0]    den,
	input  logic [idw_pkg::REM_W-1:0]   rem0,
	input  logic [idw_pkg::NUM_W-1:0]   num,
	input  logic [idw_pkg::STEP_W-1:0]  steps,
	output logic                        done,
	output logic [idw_pkg::WT_W-1:0]    quot
);
	import idw_pkg::*;

	logic [REM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  num_q;
	logic [D2_W-1:0]   den_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WT_W-1:0]   quot_q;
	logic [REM_W-1:0]  rem_sh;
	logic              fits;

	// one quotient bit a cycle, remainder shifted left with the next dividend bit
	assign rem_sh = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
	assign fits   = rem_sh >= REM_W'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem0;
			num_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? rem_sh - REM_W'(den_q) : rem_sh;
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[WT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("divider started while busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while still busy");
endmodule

FILE: src/idw_sqrt.sv
module idw_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [idw_pkg::ROOT_IN_W-1:0]  val,
	output logic                           done,
	output logic [idw_pkg::WT_W-1:0]       root
);
	import idw_pkg::*;

	localparam int RW = WT_W + 3;

	logic [ROOT_IN_W-1:0] val_q;
	logic [RW-1:0]        rem_q;
	logic [WT_W-1:0]      root_q;
	logic [4:0]           cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [RW-1:0]        rem_sh;
	logic [RW-1:0]        trial;
	logic                 fits;

	// two radicand bits a step, one root bit out
	assign rem_sh = {rem_q[RW-3:0], val_q[ROOT_IN_W-1 -: 2]};
	assign trial  = RW'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(WT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= val;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[ROOT_IN_W-3:0], 2'b00};
			rem_q  <= fits ? rem_sh - trial : rem_sh;
			root_q <= {root_q[WT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

	assert property (@(posedge clk) disable iff (!arst_n) start |-> !busy_q)
		else $error("root unit started while busy");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> $past(busy_q))
		else $error("root unit done without work");
endmodule

FILE: src/inverse_distance_interpolator_top.sv
// load item: written to the point table at the accepting edge; one item in flight at a time
// query: a nearest-distance scan of every table entry, ending early on an exact hit whose
//   temperature is output; then per valid point a ratio divide (skipped at the nearest
//   distance), a root if the power is odd, power/2 multiplies and an accumulate, invalid
//   entries skipped; then a final divide and the output register (serial divider and root)
// reset idles control, sets power 2, count 0, res_valid low; table undefined until loaded
module inverse_distance_interpolator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  idw_pkg::in_item_t   in_data,
	output logic                res_valid,
	input  logic                res_ready,
	output idw_pkg::out_item_t  res_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [6:0]          cfg_data
);
	import idw_pkg::*;

	idw_state_t state_q, state_d;

	logic [POW_W-1:0]  power_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_eff;
	logic [CNT_W-1:0]  j_q;
	logic [CNT_W-1:0]  j_next;
	logic              last;
	logic              pass_q;
	logic              any_q;
	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic [COORD_W-1:0] ax_q, ay_q;
	logic              ok_q;
	logic signed [TEMP_W-1:0] tref_q;
	logic [D2_W-1:0]   d2_q, dmin_q;
	logic [WT_W-1:0]   r_q, w_q;
	logic [POW_W-2:0]  k_q;
	logic [WSUM_W-1:0] wsum_q;
	logic signed [VSUM_W-1:0] vwsum_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [TEMP_W-1:0] rt_q;
	logic              rok_q;
	out_item_t         res_q;
	logic              res_valid_q;

	ref_entry_t        wr_entry, rd_entry;
	logic              ram_we;
	logic              accept;

	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W-1:0] adx, ady;
	logic [SQ_W-1:0]   sqx, sqy;
	logic [2*WT_W-1:0] wprod;
	logic [VSUM_W-1:0] mag;
	logic [NUM_W-1:0]  fin_num;
	logic signed [WT_W:0] qs;

	logic              div_start, div_done;
	logic [D2_W-1:0]   div_den;
	logic [REM_W-1:0]  div_rem0;
	logic [NUM_W-1:0]  div_num;
	logic [STEP_W-1:0] div_steps;
	logic [WT_W-1:0]   div_quot;
	logic              sq_start, sq_done;
	logic [WT_W-1:0]   sq_root;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign n_eff     = (count_q > CNT_MAX) ? CNT_MAX : count_q;
	assign j_next    = j_q + 1'b1;
	assign last      = (j_next == n_eff);

	assign wr_entry = '{ok: in_data.temp_valid, temp: in_data.temp_in,
		y: in_data.pos_y, x: in_data.pos_x};
	assign ram_we   = accept && (in_data.action == ACT_LOAD);

	idw_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (in_data.slot[PT_W-1:0]),
		.wdata (wr_entry),
		.raddr (j_q[PT_W-1:0]),
		.rdata (rd_entry)
	);

	// distance terms from the entry just read
	assign dx  = $signed({rd_entry.x[COORD_W-1], rd_entry.x}) - $signed({cx_q[COORD_W-1], cx_q});
	assign dy  = $signed({rd_entry.y[COORD_W-1], rd_entry.y}) - $signed({cy_q[COORD_W-1], cy_q});
	assign adx = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
	assign ady = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
	assign sqx = SQ_W'(ax_q) * SQ_W'(ax_q);
	assign sqy = SQ_W'(ay_q) * SQ_W'(ay_q);
	assign wprod = (2*WT_W)'(w_q) * (2*WT_W)'(r_q);

	assign mag     = vwsum_q[VSUM_W-1] ? VSUM_W'(-vwsum_q) : VSUM_W'(vwsum_q);
	assign fin_num = {1'b0, mag, 1'b0} + NUM_W'(wsum_q);
	assign qs      = vwsum_q[VSUM_W-1] ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});

	assign div_start = (state_q == S_FIN) ||
		(state_q == S_NEXT && pass_q && ok_q && d2_q != dmin_q);
	assign div_den   = (state_q == S_FIN) ? D2_W'({wsum_q, 1'b0}) : d2_q;
	assign div_rem0  = (state_q == S_FIN) ? '0 : REM_W'(dmin_q);
	assign div_num   = (state_q == S_FIN) ? fin_num : '0;
	assign div_steps = (state_q == S_FIN) ? STEP_W'(NUM_W) : STEP_W'(RATIO_STEPS);

	assign sq_start = (state_q == S_WGT) && power_q[0];

	idw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (div_den),
		.rem0   (div_rem0),
		.num    (div_num),
		.steps  (div_steps),
		.done   (div_done),
		.quot   (div_quot)
	);

	idw_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.val    ({1'b0, r_q, W_FRAC'(0)}),
		.done   (sq_done),
		.root   (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_q <= POW_W'(2);
			count_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POWER: power_q <= cfg_data[POW_W-1:0];
				REG_COUNT: count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EMIT && (!res_valid_q || res_ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && in_data.action == ACT_QUERY) begin
					state_d = (in_data.cell_valid && n_eff != '0) ? S_RD : S_EMIT;
				end
			end
			S_RD:  state_d = S_DAT;
			S_DAT: state_d = S_SQ;
			S_SQ:  state_d = S_NEXT;
			S_NEXT: begin
				if (!pass_q) begin
					if (ok_q && d2_q == '0) begin
						state_d = S_EMIT;
					end else if (last) begin
						state_d = (any_q || ok_q) ? S_RD : S_EMIT;
					end else begin
						state_d = S_RD;
					end
				end else if (!ok_q) begin
					state_d = last ? S_FIN : S_RD;
				end else begin
					state_d = (d2_q == dmin_q) ? S_WGT : S_RATIO;
				end
			end
			S_RATIO: if (div_done) state_d = S_WGT;
			S_WGT:   state_d = power_q[0] ? S_ROOT : S_POW;
			S_ROOT:  if (sq_done) state_d = S_POW;
			S_POW:   if (k_q == '0) state_d = S_ACC;
			S_ACC:   state_d = last ? S_FIN : S_RD;
			S_FIN:   state_d = S_QUO;
			S_QUO:   if (div_done) state_d = S_EMIT;
			S_EMIT:  if (!res_valid_q || res_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cx_q   <= in_data.pos_x;
				cy_q   <= in_data.pos_y;
				j_q    <= '0;
				pass_q <= 1'b0;
				any_q  <= 1'b0;
				wsum_q <= '0;
				vwsum_q <= '0;
				rt_q   <= '0;
				rok_q  <= 1'b0;
			end
			S_DAT: begin
				ax_q   <= adx;
				ay_q   <= ady;
				ok_q   <= rd_entry.ok;
				tref_q <= rd_entry.temp;
			end
			S_SQ: d2_q <= D2_W'(sqx) + D2_W'(sqy);
			S_NEXT: begin
				if (!pass_q) begin
					if (ok_q && d2_q == '0) begin
						rt_q  <= tref_q;
						rok_q <= 1'b1;
					end else begin
						if (ok_q && (!any_q || d2_q < dmin_q)) begin
							dmin_q <= d2_q;
						end
						any_q <= any_q || ok_q;
						j_q   <= last ? '0 : j_next;
						if (last) begin
							pass_q <= 1'b1;
						end
					end
				end else if (!ok_q) begin
					j_q <= j_next;
				end else begin
					r_q <= W_ONE;
				end
			end
			S_RATIO: if (div_done) r_q <= div_quot;
			S_WGT: begin
				w_q <= W_ONE;
				k_q <= power_q[POW_W-1:1];
			end
			S_ROOT: if (sq_done) w_q <= sq_root;
			S_POW: begin
				if (k_q != '0) begin
					w_q <= wprod[W_FRAC +: WT_W];
					k_q <= k_q - 1'b1;
				end else begin
					prod_q <= PROD_W'($signed({1'b0, w_q})) * PROD_W'(tref_q);
					wsum_q <= wsum_q + WSUM_W'(w_q);
				end
			end
			S_ACC: begin
				vwsum_q <= vwsum_q + VSUM_W'(prod_q);
				j_q     <= j_next;
			end
			S_QUO: begin
				if (div_done) begin
					rt_q  <= qs[TEMP_W-1:0];
					rok_q <= 1'b1;
				end
			end
			S_EMIT: begin
				if (!res_valid_q || res_ready) begin
					res_q <= '{temp_out: rt_q, out_valid: rok_q};
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assert property (@(posedge clk) disable iff (!arst_n) state_q == S_RD |-> j_q < n_eff)
		else $error("table walk past the point count");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD && pass_q) |-> any_q)
		else $error("weighting pass without a valid point");
	assert property (@(posedge clk) disable iff (!arst_n) state_q == S_POW |-> w_q <= W_ONE)
		else $error("weight above one");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> wsum_q >= WSUM_W'(W_ONE))
		else $error("weight sum below one at final divide");
endmodule
